// ----- rtl/core/tstp_pkg.sv -----
// shared types and constants for the section timing profiler
package tstp_pkg;

  localparam int unsigned Entries  = 128;
  localparam int unsigned IdxBits  = 7;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned SumBits  = 64;
  localparam int unsigned CntBits  = 32;
  localparam int unsigned UsedBits = 8;

  typedef enum logic [1:0] {
    OpBegin = 2'd0,
    OpEnd   = 2'd1,
    OpRead  = 2'd2,
    OpRead3 = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEndIgn   = 2'd1,
    StFull     = 2'd2,
    StReadUnused = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [TagBits-1:0]  tag;
    logic [TimeBits-1:0] timestamp;
    logic [IdxBits-1:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [IdxBits-1:0]  entry;
    logic [TagBits-1:0]  entry_tag;
    logic [CntBits-1:0]  call_count;
    logic [SumBits-1:0]  total_ticks;
    logic [TimeBits-1:0] min_ticks;
    logic [TimeBits-1:0] max_ticks;
    logic [TimeBits-1:0] trimmed_average;
    logic                average_valid;
    logic [UsedBits-1:0] entries_used;
  } rsp_t;

  // one statistics record as kept in the memory
  typedef struct packed {
    logic [TagBits-1:0]  tag;
    logic [TimeBits-1:0] start;
    logic [SumBits-1:0]  sum;
    logic [TimeBits-1:0] mn;
    logic [TimeBits-1:0] mx;
    logic [CntBits-1:0]  cnt;
  } rec_t;

endpackage

// ----- rtl/core/tagged_section_timing_profiler_top.sv -----
// section timing profiler: tag search, statistics memory and trimmed average divider
// timing: begins, ends and reads in range pass the record update and the divider before
//   answering; ignored ends and full-table begins answer after the scan, and reads of
//   unused entries answer straight from idle
// flow: one request at a time, the next is taken only after the result leaves the output
//   register; the 64-step radix-2 divide loop and the tag scan take most of the time
// reset: asynchronous active low, clears control state, active flags and used count;
//   memories hold no reset and are only read where written
module tagged_section_timing_profiler_top import tstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SScan  = 7'b0000010,
    SRdRec = 7'b0000100,
    SUpd   = 7'b0001000,
    SDiv   = 7'b0010000,
    SFin   = 7'b0100000,
    SOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic [UsedBits-1:0] used_q;
  logic [Entries-1:0]  act_q;

  // memories: tag store scanned separately, record store read-modify-write
  logic [TagBits-1:0] tag_mem [Entries];
  rec_t               rec_mem [Entries];
  logic [TagBits-1:0] tag_rd_q;
  rec_t               rec_rd_q;
  logic [IdxBits-1:0] tag_ra, rec_ra;
  logic               rec_we, tag_we;
  logic [IdxBits-1:0] wa;
  rec_t               rec_wd;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[wa] <= req_q.tag;
    tag_rd_q <= tag_mem[tag_ra];
  end
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[wa] <= rec_wd;
    rec_rd_q <= rec_mem[rec_ra];
  end

  // scan pointer: index being compared and one issued ahead
  logic [UsedBits-1:0] scan_q, scan_d;  // index whose tag sits in tag_rd_q
  logic                scan_vq, scan_vd;
  logic [IdxBits-1:0]  ent_q, ent_d;
  logic                new_q, new_d;

  // divider
  logic [SumBits-1:0] num_q, num_d;
  logic [SumBits-1:0] rem_q, rem_d;
  logic [CntBits-1:0] den_q, den_d;
  logic [6:0]         dcnt_q, dcnt_d;
  logic [SumBits:0]   rem_sh;
  rec_t               cur_q, cur_d;

  // elapsed and update datapath
  logic [TimeBits-1:0] elapsed;
  logic [SumBits:0]    sum_add;
  logic [SumBits:0]    mnmx;

  rsp_t rsp_d;
  logic [UsedBits-1:0] used_d;
  logic [Entries-1:0]  act_d;
  req_t req_d;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = rsp_q;

  assign elapsed = req_q.timestamp - rec_rd_q.start;

  assign sum_add = {1'b0, rec_rd_q.sum} + {{(SumBits-TimeBits+1){1'b0}}, elapsed};
  assign mnmx    = {{(SumBits-TimeBits+1){1'b0}}, cur_q.mn} +
                   {{(SumBits-TimeBits+1){1'b0}}, cur_q.mx};
  assign rem_sh  = {rem_q, num_q[SumBits-1]};

  always_comb begin
    state_d = state_q; req_d = req_q; rsp_d = rsp_q; used_d = used_q; act_d = act_q;
    scan_d = scan_q; scan_vd = 1'b0; ent_d = ent_q; new_d = new_q;
    num_d = num_q; rem_d = rem_q; den_d = den_q; dcnt_d = dcnt_q; cur_d = cur_q;
    tag_ra = scan_q[IdxBits-1:0]; rec_ra = ent_q;
    tag_we = 1'b0; rec_we = 1'b0; wa = ent_q; rec_wd = rec_rd_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          rsp_d = '0;
          scan_d = '0;
          tag_ra = '0;
          if (in_data_i.operation == OpBegin || in_data_i.operation == OpEnd) begin
            scan_vd = (used_q != '0);
            state_d = SScan;
          end else begin
            ent_d = in_data_i.entry_index;
            if ({1'b0, in_data_i.entry_index} >= used_q) begin
              rsp_d.status = StReadUnused;
              rsp_d.entry  = in_data_i.entry_index;
              rsp_d.entries_used = used_q;
              state_d = SOut;
            end else begin
              rec_ra = in_data_i.entry_index;
              state_d = SRdRec;
            end
          end
        end
      end
      SScan: begin
        // tag_rd_q holds entry scan_q when scan_vq
        if (scan_vq && tag_rd_q == req_q.tag) begin
          ent_d = scan_q[IdxBits-1:0]; new_d = 1'b0; rec_ra = scan_q[IdxBits-1:0];
          if (req_q.operation == OpEnd && !act_q[scan_q[IdxBits-1:0]]) begin
            rsp_d.status = StEndIgn; rsp_d.entry = scan_q[IdxBits-1:0];
            rsp_d.entries_used = used_q; state_d = SOut;
          end else state_d = SRdRec;
        end else if (!scan_vq || scan_q + 1'b1 >= used_q) begin
          // not found
          if (req_q.operation == OpEnd) begin
            rsp_d.status = StEndIgn; rsp_d.entries_used = used_q; state_d = SOut;
          end else if (used_q >= UsedBits'(Entries)) begin
            rsp_d.status = StFull; rsp_d.entries_used = used_q; state_d = SOut;
          end else begin
            ent_d = used_q[IdxBits-1:0]; new_d = 1'b1; state_d = SUpd;
          end
        end else begin
          scan_d = scan_q + 1'b1; tag_ra = scan_d[IdxBits-1:0]; scan_vd = 1'b1;
        end
      end
      SRdRec: begin
        state_d = SUpd;
      end
      SUpd: begin
        cur_d = rec_rd_q;
        if (req_q.operation == OpBegin) begin
          if (new_q) begin
            cur_d.tag = req_q.tag; cur_d.sum = '0; cur_d.mn = '1;
            cur_d.mx = '0; cur_d.cnt = '0;
            tag_we = 1'b1; used_d = used_q + 1'b1;
          end
          cur_d.start = req_q.timestamp;
          act_d[ent_q] = 1'b1;
          rec_we = 1'b1;
        end else if (req_q.operation == OpEnd) begin
          cur_d.sum = sum_add[SumBits] ? '1 : sum_add[SumBits-1:0];
          if (elapsed < rec_rd_q.mn) cur_d.mn = elapsed;
          if (elapsed > rec_rd_q.mx) cur_d.mx = elapsed;
          if (rec_rd_q.cnt != '1) cur_d.cnt = rec_rd_q.cnt + 1'b1;
          act_d[ent_q] = 1'b0;
          rec_we = 1'b1;
        end
        rec_wd = cur_d;
        state_d = SDiv;
        dcnt_d = '0;
        rem_d = '0;
        num_d = '0;
        den_d = '0;
        new_d = 1'b0;
      end
      SDiv: begin
        if (dcnt_q == '0) begin
          // set up numerator and denominator from committed record
          num_d = (cur_q.cnt > 32'd2 && {1'b0, cur_q.sum} >= mnmx) ?
                  cur_q.sum - mnmx[SumBits-1:0] : '0;
          den_d = cur_q.cnt - 32'd2;
          rem_d = '0;
          dcnt_d = 7'd1;
        end else begin
          if (rem_sh >= {{(SumBits-CntBits+1){1'b0}}, den_q})
            rem_d = rem_sh[SumBits-1:0] - {{(SumBits-CntBits){1'b0}}, den_q};
          else rem_d = rem_sh[SumBits-1:0];
          num_d = {num_q[SumBits-2:0],
                   rem_sh >= {{(SumBits-CntBits+1){1'b0}}, den_q}};
          dcnt_d = dcnt_q + 1'b1;
          if (dcnt_q == 7'(SumBits)) state_d = SFin;
        end
      end
      SFin: begin
        rsp_d.status = StOk;
        rsp_d.entry = ent_q;
        rsp_d.entry_tag = cur_q.tag;
        rsp_d.call_count = cur_q.cnt;
        rsp_d.total_ticks = cur_q.sum;
        rsp_d.min_ticks = cur_q.mn;
        rsp_d.max_ticks = cur_q.mx;
        rsp_d.average_valid = (cur_q.cnt > 32'd2);
        rsp_d.trimmed_average = !rsp_d.average_valid ? '0 :
          (num_q[SumBits-1:TimeBits] != '0) ? '1 : num_q[TimeBits-1:0];
        rsp_d.entries_used = used_q;
        state_d = SOut;
      end
      SOut: begin
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; used_q <= '0; act_q <= '0; scan_vq <= 1'b0;
      dcnt_q <= '0;
    end else begin
      state_q <= state_d; used_q <= used_d; act_q <= act_d; scan_vq <= scan_vd;
      dcnt_q <= dcnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d; scan_q <= scan_d; ent_q <= ent_d; new_q <= new_d;
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; cur_q <= cur_d;
  end

  // assertions
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedBits'(Entries)) else $error("used count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) |-> in_stall_o) else $error("accept while result pending");
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
    else $error("used count jumped");

endmodule
